// ===== design/cht_pkg.sv =====
package cht_pkg;

  localparam int unsigned HandleW = 7;
  localparam int unsigned ObjW    = 32;
  localparam int unsigned TypeW   = 4;
  localparam int unsigned RightsW = 8;
  localparam int unsigned OwnerW  = 16;
  localparam int unsigned CountW  = 7;

  typedef enum logic [2:0] {
    ACT_ADD      = 3'd0,
    ACT_LOOKUP   = 3'd1,
    ACT_CLOSE    = 3'd2,
    ACT_TRANSFER = 3'd3,
    ACT_CLOSEALL = 3'd4
  } action_e;

  typedef enum logic [2:0] {
    OP_ADD,
    OP_LOOKUP,
    OP_CLOSE,
    OP_TRANSFER,
    OP_CLOSEALL,
    OP_BAD
  } op_e;

  typedef enum logic [2:0] {
    ST_OK          = 3'd0,
    ST_INVALID     = 3'd1,
    ST_EXHAUSTED   = 3'd2,
    ST_DENIED      = 3'd3,
    ST_LOOKUP_FAIL = 3'd4
  } status_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_EVAL,
    S_CA,
    S_CA_CHK,
    S_CA_END,
    S_EMIT
  } state_e;

  // Classified item as it sits in the queue
  typedef struct packed {
    op_e                  op;
    logic                 h_ok;
    logic [HandleW-1:0]   handle;
    logic [ObjW-1:0]      obj;
    logic [TypeW-1:0]     htype;
    logic [RightsW-1:0]   rights;
    logic [OwnerW-1:0]    owner;
  } item_t;

  // One table entry
  typedef struct packed {
    logic [TypeW-1:0]   htype;
    logic [RightsW-1:0] rights;
    logic [ObjW-1:0]    obj;
    logic [OwnerW-1:0]  owner;
  } ent_t;

  // One result beat
  typedef struct packed {
    status_e            status;
    logic [HandleW-1:0] handle;
    logic [ObjW-1:0]    obj;
    logic               rel;
    logic               ret;
    logic               last;
  } res_t;

  // Queue head toward the back part
  typedef struct packed {
    logic  valid;
    item_t item;
  } qhead_t;

endpackage

// ===== design/cht_front.sv =====
module cht_front #(
  parameter int unsigned TABLE_DEPTH = 64
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  logic [2:0]                  action_i,
  input  logic [cht_pkg::HandleW-1:0] handle_in_i,
  input  logic [cht_pkg::ObjW-1:0]    object_ref_i,
  input  logic [cht_pkg::TypeW-1:0]   handle_type_i,
  input  logic [cht_pkg::RightsW-1:0] rights_mask_i,
  input  logic [cht_pkg::OwnerW-1:0]  owner_id_i,
  output cht_pkg::qhead_t             head_o,
  input  logic                        pop_i
);
  import cht_pkg::*;

  item_t       q_q [2];
  logic        wr_q, wr_d, rd_q, rd_d;
  logic [1:0]  cnt_q, cnt_d;
  logic        push;
  item_t       cls;

  // Classify the incoming beat
  always_comb begin
    cls.handle = handle_in_i;
    cls.obj    = object_ref_i;
    cls.htype  = handle_type_i;
    cls.rights = rights_mask_i;
    cls.owner  = owner_id_i;
    cls.h_ok   = (handle_in_i != '0) && (int'(handle_in_i) <= int'(TABLE_DEPTH));
    case (action_i)
      ACT_ADD:      cls.op = OP_ADD;
      ACT_LOOKUP:   cls.op = OP_LOOKUP;
      ACT_CLOSE:    cls.op = OP_CLOSE;
      ACT_TRANSFER: cls.op = OP_TRANSFER;
      ACT_CLOSEALL: cls.op = OP_CLOSEALL;
      default:      cls.op = OP_BAD;
    endcase
  end

  assign in_stall_o = (cnt_q == 2'd2);
  assign push       = in_valid_i && !in_stall_o;

  assign head_o.valid = (cnt_q != 2'd0);
  assign head_o.item  = q_q[rd_q];

  // Advance queue pointers
  always_comb begin
    wr_d  = push ? ~wr_q : wr_q;
    rd_d  = pop_i ? ~rd_q : rd_q;
    cnt_d = cnt_q + {1'b0, push} - {1'b0, pop_i};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      q_q[wr_q] <= cls;
    end
  end

endmodule

// ===== design/cht_back.sv =====
module cht_back #(
  parameter int unsigned TABLE_DEPTH = 64
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  cht_pkg::qhead_t             head_i,
  output logic                        pop_o,
  input  logic [cht_pkg::RightsW-1:0] xfer_mask_i,
  input  logic [cht_pkg::TypeW-1:0]   pipe_type_i,
  output cht_pkg::res_t               out_o,
  output logic                        out_valid_o,
  input  logic                        out_stall_i
);
  import cht_pkg::*;

  localparam int unsigned IW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam logic [IW-1:0] LastIdx  = IW'(TABLE_DEPTH - 1);
  localparam logic [IW-1:0] StartIdx = IW'(1 % TABLE_DEPTH);

  state_e            state_q, state_d;
  item_t             cur_q, cur_d;
  ent_t              ent_q, ent_d;
  res_t              res_q, res_d;
  res_t              pend_q, pend_d;
  logic              pend_v_q, pend_v_d;
  logic [IW-1:0]     idx_q, idx_d;
  logic [IW-1:0]     start_q, start_d;
  logic [CountW-1:0] live_q, live_d;
  logic [TABLE_DEPTH-1:0] valid_q, valid_d;
  res_t              out_q, out_d;
  logic              out_v_q, out_v_d;

  ent_t              mem [TABLE_DEPTH];
  ent_t              rd_q;
  logic              re, we;
  logic [IW-1:0]     ra, wa;
  ent_t              wd;

  logic              out_free, emit;
  res_t              emit_res;
  item_t             hd;
  logic [IW-1:0]     hd_idx, cur_idx, idx_nxt;
  logic              hd_live, add_null, add_full, idx_last;
  logic              lk_fail, xf_deny, ca_match;

  assign out_free = !out_v_q || !out_stall_i;
  assign hd       = head_i.item;
  assign hd_idx   = IW'(hd.handle - HandleW'(1));
  assign cur_idx  = IW'(cur_q.handle - HandleW'(1));
  assign hd_live  = hd.h_ok && valid_q[hd_idx];
  assign add_null = (hd.obj == '0);
  assign add_full = (int'(live_q) >= int'(TABLE_DEPTH));
  assign idx_last = (idx_q == LastIdx);
  assign idx_nxt  = idx_last ? '0 : IW'(idx_q + IW'(1));
  assign lk_fail  = ((cur_q.htype != '0) && (rd_q.htype != cur_q.htype)) ||
                    ((cur_q.rights != '0) && ((rd_q.rights & cur_q.rights) != cur_q.rights));
  assign xf_deny  = ((rd_q.rights & xfer_mask_i) == '0);
  assign ca_match = (rd_q.owner == cur_q.owner);

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (head_i.valid) begin
          case (hd.op)
            OP_ADD:      state_d = (add_null || add_full) ? S_EMIT : S_SCAN;
            OP_LOOKUP,
            OP_CLOSE,
            OP_TRANSFER: state_d = hd_live ? S_EVAL : S_EMIT;
            OP_CLOSEALL: state_d = S_CA;
            default:     state_d = S_EMIT;
          endcase
        end
      end
      S_EVAL: begin
        if (cur_q.op == OP_TRANSFER && !xf_deny) state_d = S_SCAN;
        else                                     state_d = S_EMIT;
      end
      S_SCAN: begin
        if (!valid_q[idx_q]) state_d = S_EMIT;
      end
      S_CA: begin
        if (valid_q[idx_q])  state_d = S_CA_CHK;
        else if (idx_last)   state_d = S_CA_END;
      end
      S_CA_CHK: begin
        if (!(ca_match && pend_v_q && !out_free)) begin
          state_d = idx_last ? S_CA_END : S_CA;
        end
      end
      S_CA_END: begin
        if (!pend_v_q || out_free) state_d = S_IDLE;
      end
      S_EMIT: begin
        if (out_free) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  // Datapath and table updates
  always_comb begin
    cur_d    = cur_q;
    ent_d    = ent_q;
    res_d    = res_q;
    pend_d   = pend_q;
    pend_v_d = pend_v_q;
    idx_d    = idx_q;
    start_d  = start_q;
    live_d   = live_q;
    valid_d  = valid_q;
    pop_o    = 1'b0;
    re       = 1'b0;
    ra       = idx_q;
    we       = 1'b0;
    wa       = idx_q;
    wd       = ent_q;
    emit     = 1'b0;
    emit_res = res_q;
    case (state_q)
      S_IDLE: begin
        if (head_i.valid) begin
          pop_o = 1'b1;
          cur_d = hd;
          res_d = '{status: ST_INVALID, default: '0};
          res_d.last = 1'b1;
          case (hd.op)
            OP_ADD: begin
              if (!add_null && add_full) res_d.status = ST_EXHAUSTED;
              ent_d = '{htype: hd.htype, rights: hd.rights, obj: hd.obj, owner: hd.owner};
              idx_d = start_q;
            end
            OP_LOOKUP,
            OP_CLOSE,
            OP_TRANSFER: begin
              if (hd.op == OP_LOOKUP) res_d.status = ST_LOOKUP_FAIL;
              re = hd_live;
              ra = hd_idx;
            end
            OP_CLOSEALL: begin
              idx_d    = '0;
              pend_v_d = 1'b0;
            end
            default: ;
          endcase
        end
      end
      S_EVAL: begin
        res_d = '{status: ST_OK, default: '0};
        res_d.last = 1'b1;
        case (cur_q.op)
          OP_LOOKUP: begin
            if (lk_fail) res_d.status = ST_LOOKUP_FAIL;
            else         res_d.obj    = rd_q.obj;
          end
          OP_CLOSE: begin
            valid_d[cur_idx] = 1'b0;
            live_d           = live_q - CountW'(1);
            res_d.handle     = cur_q.handle;
            res_d.obj        = rd_q.obj;
            res_d.rel        = (rd_q.obj != '0);
          end
          default: begin
            if (xf_deny) begin
              res_d.status = ST_DENIED;
            end else begin
              valid_d[cur_idx] = 1'b0;
              live_d           = live_q - CountW'(1);
              ent_d = '{htype: rd_q.htype, rights: rd_q.rights, obj: rd_q.obj,
                        owner: cur_q.owner};
              idx_d = start_q;
            end
          end
        endcase
      end
      S_SCAN: begin
        if (!valid_q[idx_q]) begin
          we             = 1'b1;
          valid_d[idx_q] = 1'b1;
          live_d         = live_q + CountW'(1);
          start_d        = idx_nxt;
          res_d = '{status: ST_OK, default: '0};
          res_d.last   = 1'b1;
          res_d.handle = HandleW'(idx_q) + HandleW'(1);
          if (cur_q.op == OP_TRANSFER) begin
            res_d.obj = ent_q.obj;
            res_d.ret = (ent_q.htype == pipe_type_i);
          end
        end else begin
          idx_d = idx_nxt;
        end
      end
      S_CA: begin
        re = valid_q[idx_q];
        if (!valid_q[idx_q]) idx_d = idx_nxt;
      end
      S_CA_CHK: begin
        if (!ca_match) begin
          idx_d = idx_nxt;
        end else if (!pend_v_q || out_free) begin
          emit           = pend_v_q;
          emit_res       = pend_q;
          valid_d[idx_q] = 1'b0;
          live_d         = live_q - CountW'(1);
          pend_v_d       = 1'b1;
          pend_d = '{status: ST_OK, default: '0};
          pend_d.handle  = HandleW'(idx_q) + HandleW'(1);
          pend_d.obj     = rd_q.obj;
          pend_d.rel     = (rd_q.obj != '0);
          idx_d          = idx_nxt;
        end
      end
      S_CA_END: begin
        if (pend_v_q && out_free) begin
          emit          = 1'b1;
          emit_res      = pend_q;
          emit_res.last = 1'b1;
          pend_v_d      = 1'b0;
        end
      end
      S_EMIT: begin
        emit = out_free;
      end
      default: ;
    endcase
  end

  // Output register
  always_comb begin
    out_d   = out_q;
    out_v_d = out_v_q;
    if (emit) begin
      out_d   = emit_res;
      out_v_d = 1'b1;
    end else if (!out_stall_i) begin
      out_v_d = 1'b0;
    end
  end

  assign out_o       = out_q;
  assign out_valid_o = out_v_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      pend_v_q <= 1'b0;
      start_q  <= StartIdx;
      live_q   <= '0;
      valid_q  <= '0;
      out_v_q  <= 1'b0;
    end else begin
      state_q  <= state_d;
      pend_v_q <= pend_v_d;
      start_q  <= start_d;
      live_q   <= live_d;
      valid_q  <= valid_d;
      out_v_q  <= out_v_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cur_q  <= cur_d;
    ent_q  <= ent_d;
    res_q  <= res_d;
    pend_q <= pend_d;
    idx_q  <= idx_d;
    out_q  <= out_d;
  end

  // Entry memory, registered read
  always_ff @(posedge clk_i) begin
    if (we) begin
      mem[wa] <= wd;
    end
    if (re) begin
      rd_q <= mem[ra];
    end
  end

endmodule

// ===== design/capability_handle_table.sv =====
// Capability handle table. A front stage takes one item per beat into a two-deep
// queue, and stalls its input while the queue is full; a back sequencer executes
// it against the entry table (one memory read or write per cycle) and holds each
// result beat in an output register. Add scans one slot per cycle from the
// next-fit start slot; transfer reads and checks the entry first and then scans.
// Close-all sweeps every slot, giving one beat per freed entry with last set on
// the final one (no beat when the owner has none). A stalled result beat holds
// the sequencer until the output register is free.
module capability_handle_table #(
  parameter int unsigned TABLE_DEPTH = 64
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  logic                        cfg_index_i,
  input  logic [7:0]                  cfg_wdata_i,
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  logic [2:0]                  action_i,
  input  logic [cht_pkg::HandleW-1:0] handle_in_i,
  input  logic [cht_pkg::ObjW-1:0]    object_ref_i,
  input  logic [cht_pkg::TypeW-1:0]   handle_type_i,
  input  logic [cht_pkg::RightsW-1:0] rights_mask_i,
  input  logic [cht_pkg::OwnerW-1:0]  owner_id_i,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output logic [2:0]                  status_o,
  output logic [cht_pkg::HandleW-1:0] handle_out_o,
  output logic [cht_pkg::ObjW-1:0]    object_out_o,
  output logic                        release_object_o,
  output logic                        retarget_object_o,
  output logic                        last_o
);
  import cht_pkg::*;

  localparam logic CfgXferMask = 1'b0;
  localparam logic CfgPipeType = 1'b1;

  logic [RightsW-1:0] xfer_mask_q;
  logic [TypeW-1:0]   pipe_type_q;
  qhead_t             head;
  logic               pop;
  res_t               res;

  // Hold configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      xfer_mask_q <= RightsW'(1);
      pipe_type_q <= TypeW'(1);
    end else if (cfg_we_i) begin
      if (cfg_index_i == CfgXferMask) xfer_mask_q <= cfg_wdata_i;
      if (cfg_index_i == CfgPipeType) pipe_type_q <= cfg_wdata_i[TypeW-1:0];
    end
  end

  cht_front #(.TABLE_DEPTH(TABLE_DEPTH)) u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .action_i      (action_i),
    .handle_in_i   (handle_in_i),
    .object_ref_i  (object_ref_i),
    .handle_type_i (handle_type_i),
    .rights_mask_i (rights_mask_i),
    .owner_id_i    (owner_id_i),
    .head_o        (head),
    .pop_i         (pop)
  );

  cht_back #(.TABLE_DEPTH(TABLE_DEPTH)) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .head_i      (head),
    .pop_o       (pop),
    .xfer_mask_i (xfer_mask_q),
    .pipe_type_i (pipe_type_q),
    .out_o       (res),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i)
  );

  assign status_o          = res.status;
  assign handle_out_o      = res.handle;
  assign object_out_o      = res.obj;
  assign release_object_o  = res.rel;
  assign retarget_object_o = res.ret;
  assign last_o            = res.last;

endmodule
